@@ hdl/common_neighbor_structure_classifier_defines.svh @@
// assertion macros shared by the classifier
`ifndef COMMON_NEIGHBOR_STRUCTURE_CLASSIFIER_DEFINES_SVH
`define COMMON_NEIGHBOR_STRUCTURE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, off during reset
`define CNSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cnsc same-cycle check failed");

// next-cycle implication, off during reset
`define CNSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cnsc next-cycle check failed");

`endif

@@ hdl/cnsc_pkg.sv @@
`default_nettype none

package cnsc_pkg;

	// row geometry
	localparam int ROW_W = 14;
	localparam int ROW_SLOTS = 14;
	localparam int IDX_W = $clog2(ROW_SLOTS);
	localparam int HALF = ROW_SLOTS / 2;
	localparam int MAX_NEIGHBORS_DEF = 14;

	// neighbor counts that get a full analysis
	localparam int N12 = 12;
	localparam int N14 = 14;

	// tally targets
	localparam int N_ALL12 = 12;
	localparam int N_HALF12 = 6;
	localparam int N_BCC4 = 6;
	localparam int N_BCC6 = 8;

	// datapath widths
	localparam int BOND_W = 4;
	localparam int SUM_W = 8;
	localparam int NB_W = SUM_W - 1;
	localparam int TALLY_W = 4;
	localparam int QUEUE_DEPTH = 2;

	// result codes
	localparam int CLASS_W = 3;
	localparam logic [CLASS_W-1:0] CLASS_FCC = 3'd0;
	localparam logic [CLASS_W-1:0] CLASS_HCP = 3'd1;
	localparam logic [CLASS_W-1:0] CLASS_BCC = 3'd2;
	localparam logic [CLASS_W-1:0] CLASS_ICO = 3'd3;
	localparam logic [CLASS_W-1:0] CLASS_OTHER = 3'd4;

	typedef logic [ROW_W-1:0] row_t;
	typedef row_t [ROW_SLOTS-1:0] row_set_t;

	localparam row_t ROW_MASK12 = row_t'((1 << N12) - 1);

	typedef enum logic [1:0] {
		KIND_12,
		KIND_14,
		KIND_OTHER
	} kind_t;

	// one atom handed from front to back
	typedef struct packed {
		row_set_t rows;
		kind_t kind;
	} job_t;

	// queue status seen by both sides
	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

	// signature: set size, bonds inside, max and min member bonds
	typedef struct packed {
		logic [BOND_W-1:0] size;
		logic [NB_W-1:0] bonds;
		logic [BOND_W-1:0] hi;
		logic [BOND_W-1:0] lo;
	} sig_t;

	localparam sig_t SIG_4211 = '{size: 4'd4, bonds: 7'd2, hi: 4'd1, lo: 4'd1};
	localparam sig_t SIG_4220 = '{size: 4'd4, bonds: 7'd2, hi: 4'd2, lo: 4'd0};
	localparam sig_t SIG_5522 = '{size: 4'd5, bonds: 7'd5, hi: 4'd2, lo: 4'd2};
	localparam sig_t SIG_4422 = '{size: 4'd4, bonds: 7'd4, hi: 4'd2, lo: 4'd2};
	localparam sig_t SIG_6622 = '{size: 4'd6, bonds: 7'd6, hi: 4'd2, lo: 4'd2};

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DRAIN,
		BK_RESULT
	} bk_state_t;

	// population count of one row
	function automatic logic [BOND_W-1:0] ones_row(row_t v);
		logic [BOND_W-1:0] n;
		n = '0;
		for (int i = 0; i < ROW_W; i++) begin
			n = n + BOND_W'(v[i]);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

@@ hdl/cnsc_queue.sv @@
`default_nettype none

module cnsc_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire cnsc_pkg::job_t    push_job,
	input  wire logic              pop,
	output cnsc_pkg::q_stat_t      stat,
	output cnsc_pkg::job_t         pop_job
);

	localparam int PTR_W = $clog2(cnsc_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(cnsc_pkg::QUEUE_DEPTH + 1);

	cnsc_pkg::job_t entries_q [cnsc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// status and head word
	assign stat.valid = (count_q != '0);
	assign stat.full = (count_q == CNT_W'(cnsc_pkg::QUEUE_DEPTH));
	assign pop_job = entries_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/cnsc_front.sv @@
`default_nettype none

module cnsc_front #(
	parameter int MAX_NEIGHBORS = cnsc_pkg::MAX_NEIGHBORS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       row_valid,
	output logic                            row_stall,
	input  wire logic [cnsc_pkg::ROW_W-1:0] adjacency_row,
	input  wire logic                       last_row,
	input  wire cnsc_pkg::q_stat_t          q_stat,
	output logic                            push,
	output cnsc_pkg::job_t                  job
);

	localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);

	cnsc_pkg::row_set_t rows_q;
	logic [CNT_W-1:0] count_q;
	logic ovf_q;

	logic accept;
	logic room;
	logic slot;
	cnsc_pkg::row_set_t rows_nx;
	logic [CNT_W-1:0] cnt_nx;
	logic ovf_nx;
	cnsc_pkg::kind_t kind_c;

	// handshake
	assign row_stall = q_stat.full;
	assign accept = row_valid && !q_stat.full;
	assign push = accept && last_row;

	// store the word and classify the atom by row count
	always_comb begin
		room = (count_q < CNT_W'(MAX_NEIGHBORS));
		slot = (count_q < CNT_W'(cnsc_pkg::ROW_SLOTS));
		rows_nx = rows_q;
		if (slot) begin
			rows_nx[count_q[cnsc_pkg::IDX_W-1:0]] = adjacency_row;
		end
		cnt_nx = room ? count_q + CNT_W'(1) : count_q;
		ovf_nx = ovf_q || !room;
		if (ovf_nx) begin
			kind_c = cnsc_pkg::KIND_OTHER;
		end else if (cnt_nx == CNT_W'(cnsc_pkg::N12)) begin
			kind_c = cnsc_pkg::KIND_12;
		end else if (cnt_nx == CNT_W'(cnsc_pkg::N14)) begin
			kind_c = cnsc_pkg::KIND_14;
		end else begin
			kind_c = cnsc_pkg::KIND_OTHER;
		end
	end

	assign job.rows = rows_nx;
	assign job.kind = kind_c;

	// row store
	always_ff @(posedge clk) begin
		if (accept) begin
			rows_q <= rows_nx;
		end
	end

	// row count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (last_row) begin
				count_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				count_q <= cnt_nx;
				ovf_q <= ovf_nx;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/cnsc_back.sv @@
`default_nettype none

module cnsc_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire cnsc_pkg::q_stat_t              q_stat,
	input  wire cnsc_pkg::job_t                 q_job,
	output logic                                pop,
	output logic                                class_valid,
	input  wire logic                           class_stall,
	output logic [cnsc_pkg::CLASS_W-1:0]        structure_class
);

	localparam int IW = cnsc_pkg::IDX_W;
	localparam int BW = cnsc_pkg::BOND_W;
	localparam int SW = cnsc_pkg::SUM_W;
	localparam int TW = cnsc_pkg::TALLY_W;

	cnsc_pkg::bk_state_t state_q;
	cnsc_pkg::bk_state_t state_nx;
	cnsc_pkg::job_t job_q;
	logic [IW-1:0] m_q;
	logic [IW-1:0] last_m;
	logic issue;
	logic load_out;

	// stage 1: member bond counts for neighbor m
	cnsc_pkg::row_t vmask;
	cnsc_pkg::row_t set_c;
	cnsc_pkg::row_t u_c [cnsc_pkg::ROW_SLOTS];
	logic [BW-1:0] bnd_c [cnsc_pkg::ROW_SLOTS];
	logic v_s1;
	cnsc_pkg::row_t set_s1;
	logic [BW-1:0] bnd_s1 [cnsc_pkg::ROW_SLOTS];

	// stage 2: signature
	logic [SW-1:0] sum0, sum1, sum_c;
	logic [BW-1:0] hi0, hi1, lo0, lo1, mb0, mb1;
	cnsc_pkg::sig_t sig_c;
	logic v_s2;
	cnsc_pkg::sig_t sig_s2;

	// stage 3: tallies
	logic [TW-1:0] tally_a_q, tally_b_q, tally_c_q;
	logic [cnsc_pkg::CLASS_W-1:0] result_c;
	logic class_valid_q;
	logic [cnsc_pkg::CLASS_W-1:0] class_q;

	assign last_m = (job_q.kind == cnsc_pkg::KIND_12) ? IW'(cnsc_pkg::N12 - 1) :
		IW'(cnsc_pkg::N14 - 1);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			cnsc_pkg::BK_IDLE: begin
				if (q_stat.valid) begin
					state_nx = (q_job.kind == cnsc_pkg::KIND_OTHER) ?
						cnsc_pkg::BK_RESULT : cnsc_pkg::BK_SCAN;
				end
			end
			cnsc_pkg::BK_SCAN: begin
				if (m_q == last_m) begin
					state_nx = cnsc_pkg::BK_DRAIN;
				end
			end
			cnsc_pkg::BK_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_nx = cnsc_pkg::BK_RESULT;
				end
			end
			cnsc_pkg::BK_RESULT: begin
				if (!class_valid_q || !class_stall) begin
					state_nx = cnsc_pkg::BK_IDLE;
				end
			end
			default: state_nx = cnsc_pkg::BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		pop = 1'b0;
		issue = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			cnsc_pkg::BK_IDLE: pop = q_stat.valid;
			cnsc_pkg::BK_SCAN: issue = 1'b1;
			cnsc_pkg::BK_DRAIN: issue = 1'b0;
			cnsc_pkg::BK_RESULT: load_out = !class_valid_q || !class_stall;
			default: issue = 1'b0;
		endcase
	end

	// common set of neighbor m and bonds of each member inside it
	always_comb begin
		vmask = (job_q.kind == cnsc_pkg::KIND_12) ? cnsc_pkg::ROW_MASK12 : '1;
		set_c = job_q.rows[m_q] & vmask & ~(cnsc_pkg::row_t'(1) << m_q);
		for (int x = 0; x < cnsc_pkg::ROW_SLOTS; x++) begin
			for (int y = 0; y < cnsc_pkg::ROW_W; y++) begin
				if (x < y) begin
					u_c[x][y] = job_q.rows[x][y];
				end else if (x > y) begin
					u_c[x][y] = job_q.rows[y][x];
				end else begin
					u_c[x][y] = 1'b0;
				end
			end
			bnd_c[x] = cnsc_pkg::ones_row(u_c[x] & set_c);
		end
	end

	// size, bond total, max and min over members, in two halves
	always_comb begin
		sum0 = '0;
		sum1 = '0;
		hi0 = '0;
		hi1 = '0;
		lo0 = '1;
		lo1 = '1;
		mb0 = '0;
		mb1 = '0;
		for (int i = 0; i < cnsc_pkg::HALF; i++) begin
			mb0 = set_s1[i] ? bnd_s1[i] : '0;
			mb1 = set_s1[i + cnsc_pkg::HALF] ? bnd_s1[i + cnsc_pkg::HALF] : '0;
			sum0 = sum0 + SW'(mb0);
			sum1 = sum1 + SW'(mb1);
			if (mb0 > hi0) begin
				hi0 = mb0;
			end
			if (mb1 > hi1) begin
				hi1 = mb1;
			end
			if (set_s1[i] && bnd_s1[i] < lo0) begin
				lo0 = bnd_s1[i];
			end
			if (set_s1[i + cnsc_pkg::HALF] && bnd_s1[i + cnsc_pkg::HALF] < lo1) begin
				lo1 = bnd_s1[i + cnsc_pkg::HALF];
			end
		end
		sum_c = sum0 + sum1;
		sig_c.size = cnsc_pkg::ones_row(set_s1);
		sig_c.bonds = sum_c[SW-1:1];
		sig_c.hi = (hi0 > hi1) ? hi0 : hi1;
		sig_c.lo = (lo0 < lo1) ? lo0 : lo1;
		// empty common set has both extremes at zero
		if (set_s1 == '0) begin
			sig_c.lo = '0;
		end
	end

	// final class from tallies
	always_comb begin
		result_c = cnsc_pkg::CLASS_OTHER;
		unique case (job_q.kind)
			cnsc_pkg::KIND_12: begin
				if (tally_a_q == TW'(cnsc_pkg::N_ALL12)) begin
					result_c = cnsc_pkg::CLASS_FCC;
				end else if (tally_a_q == TW'(cnsc_pkg::N_HALF12) &&
					tally_b_q == TW'(cnsc_pkg::N_HALF12)) begin
					result_c = cnsc_pkg::CLASS_HCP;
				end else if (tally_c_q == TW'(cnsc_pkg::N_ALL12)) begin
					result_c = cnsc_pkg::CLASS_ICO;
				end
			end
			cnsc_pkg::KIND_14: begin
				if (tally_a_q == TW'(cnsc_pkg::N_BCC4) &&
					tally_b_q == TW'(cnsc_pkg::N_BCC6)) begin
					result_c = cnsc_pkg::CLASS_BCC;
				end
			end
			default: result_c = cnsc_pkg::CLASS_OTHER;
		endcase
	end

	assign class_valid = class_valid_q;
	assign structure_class = class_q;

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		set_s1 <= set_c;
		for (int x = 0; x < cnsc_pkg::ROW_SLOTS; x++) begin
			bnd_s1[x] <= bnd_c[x];
		end
		sig_s2 <= sig_c;
		if (load_out) begin
			class_q <= result_c;
		end
	end

	// control, pipeline valids and tallies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cnsc_pkg::BK_IDLE;
			m_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			tally_a_q <= '0;
			tally_b_q <= '0;
			tally_c_q <= '0;
			class_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (pop) begin
				m_q <= '0;
				tally_a_q <= '0;
				tally_b_q <= '0;
				tally_c_q <= '0;
			end else begin
				if (issue) begin
					m_q <= m_q + IW'(1);
				end
				if (v_s2) begin
					if (job_q.kind == cnsc_pkg::KIND_12) begin
						if (sig_s2 == cnsc_pkg::SIG_4211) begin
							tally_a_q <= tally_a_q + TW'(1);
						end else if (sig_s2 == cnsc_pkg::SIG_4220) begin
							tally_b_q <= tally_b_q + TW'(1);
						end else if (sig_s2 == cnsc_pkg::SIG_5522) begin
							tally_c_q <= tally_c_q + TW'(1);
						end
					end else begin
						if (sig_s2 == cnsc_pkg::SIG_4422) begin
							tally_a_q <= tally_a_q + TW'(1);
						end else if (sig_s2 == cnsc_pkg::SIG_6622) begin
							tally_b_q <= tally_b_q + TW'(1);
						end
					end
				end
			end
			if (load_out) begin
				class_valid_q <= 1'b1;
			end else if (!class_stall) begin
				class_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/common_neighbor_structure_classifier.sv @@
// rows load at one word per cycle while row_stall is low; the row marked last closes the atom
// the back end scores one neighbor per cycle during its scan of an atom
// a two-entry atom queue lets the next atom load while the previous one is scored
// arst_n clears counts, queue, pipeline valids and output valid; row store is not cleared
`default_nettype none
`include "common_neighbor_structure_classifier_defines.svh"

module common_neighbor_structure_classifier #(
	parameter int MAX_NEIGHBORS = cnsc_pkg::MAX_NEIGHBORS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         row_valid,
	output logic                              row_stall,
	input  wire logic [cnsc_pkg::ROW_W-1:0]   adjacency_row,
	input  wire logic                         last_row,
	output logic                              class_valid,
	input  wire logic                         class_stall,
	output logic [cnsc_pkg::CLASS_W-1:0]      structure_class
);

	cnsc_pkg::q_stat_t q_stat;
	cnsc_pkg::job_t push_job;
	cnsc_pkg::job_t pop_job;
	logic push;
	logic pop;

	// front: row store and atom classification by count
	cnsc_front #(
		.MAX_NEIGHBORS(MAX_NEIGHBORS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.row_valid(row_valid),
		.row_stall(row_stall),
		.adjacency_row(adjacency_row),
		.last_row(last_row),
		.q_stat(q_stat),
		.push(push),
		.job(push_job)
	);

	// atom queue
	cnsc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.stat(q_stat),
		.pop_job(pop_job)
	);

	// back: signature pipeline and pattern match
	cnsc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.q_job(pop_job),
		.pop(pop),
		.class_valid(class_valid),
		.class_stall(class_stall),
		.structure_class(structure_class)
	);

	// checks
	`CNSC_ASSERT_IMP(a_push_room, clk, arst_n, push, !q_stat.full)
	`CNSC_ASSERT_IMP(a_pop_avail, clk, arst_n, pop, q_stat.valid)
	`CNSC_ASSERT_NXT(a_push_seen, clk, arst_n, push && !pop, q_stat.valid)
	`CNSC_ASSERT_IMP(a_class_code, clk, arst_n, class_valid, structure_class <= cnsc_pkg::CLASS_OTHER)

endmodule

`default_nettype wire

@@ tb/tb_common_neighbor_structure_classifier.sv @@
`default_nettype none

module tb_common_neighbor_structure_classifier;
	import cnsc_pkg::*;

	localparam int RANDOM_ROWS = 270;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;

	logic clk;
	logic arst_n;
	logic row_valid;
	logic row_stall;
	logic [ROW_W-1:0] adjacency_row;
	logic last_row;
	logic class_valid;
	logic class_stall;
	logic [CLASS_W-1:0] structure_class;

	// shadow of the atom being loaded
	row_set_t atom_rows;
	int atom_len;
	bit atom_overflow;

	logic [CLASS_W-1:0] pending_classes[$];
	int class_tally[5];
	int rows_sent;
	int atoms_sent;
	int overflow_atoms;
	int failures;
	int long_holds;
	bit tx_steady;
	bit hold_pending;

	common_neighbor_structure_classifier uut (
		.clk(clk),
		.arst_n(arst_n),
		.row_valid(row_valid),
		.row_stall(row_stall),
		.adjacency_row(adjacency_row),
		.last_row(last_row),
		.class_valid(class_valid),
		.class_stall(class_stall),
		.structure_class(structure_class)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// counted failure, printed only for the first few
	task automatic log_failure(string msg);
		failures++;
		if (failures <= REPORT_LIMIT) begin
			$display("%s", msg);
		end
	endtask

	// size, inner bonds, max and min member bonds of neighbor m's common set
	function automatic sig_t neighbor_signature(int m, int n);
		int members[ROW_SLOTS];
		int deg[ROW_SLOTS];
		int cnt;
		int nbonds;
		int hi;
		int lo;
		sig_t s;
		cnt = 0;
		nbonds = 0;
		for (int a = 0; a < n; a++) begin
			if (a != m && atom_rows[m][a]) begin
				members[cnt] = a;
				deg[cnt] = 0;
				cnt++;
			end
		end
		// members ascend, so the pair bond comes from the lower row
		for (int a = 0; a < cnt; a++) begin
			for (int b = a + 1; b < cnt; b++) begin
				if (atom_rows[members[a]][members[b]]) begin
					nbonds++;
					deg[a]++;
					deg[b]++;
				end
			end
		end
		hi = 0;
		lo = 0;
		if (cnt > 0) begin
			hi = deg[0];
			lo = deg[0];
			for (int a = 1; a < cnt; a++) begin
				if (deg[a] > hi) hi = deg[a];
				if (deg[a] < lo) lo = deg[a];
			end
		end
		s.size = BOND_W'(cnt);
		s.bonds = NB_W'(nbonds);
		s.hi = BOND_W'(hi);
		s.lo = BOND_W'(lo);
		return s;
	endfunction

	// match the signature tallies against the four lattice patterns
	function automatic logic [CLASS_W-1:0] classify_atom();
		sig_t s;
		int n_fcc;
		int n_hcp;
		int n_ico;
		int n_b4;
		int n_b6;
		n_fcc = 0;
		n_hcp = 0;
		n_ico = 0;
		n_b4 = 0;
		n_b6 = 0;
		if (atom_overflow) return CLASS_OTHER;
		if (atom_len == N12) begin
			for (int m = 0; m < N12; m++) begin
				s = neighbor_signature(m, N12);
				if (s == SIG_4211) n_fcc++;
				else if (s == SIG_4220) n_hcp++;
				else if (s == SIG_5522) n_ico++;
			end
			if (n_fcc == N_ALL12) return CLASS_FCC;
			if (n_fcc == N_HALF12 && n_hcp == N_HALF12) return CLASS_HCP;
			if (n_ico == N_ALL12) return CLASS_ICO;
			return CLASS_OTHER;
		end
		if (atom_len == N14) begin
			for (int m = 0; m < N14; m++) begin
				s = neighbor_signature(m, N14);
				if (s == SIG_4422) n_b4++;
				else if (s == SIG_6622) n_b6++;
			end
			if (n_b4 == N_BCC4 && n_b6 == N_BCC6) return CLASS_BCC;
		end
		return CLASS_OTHER;
	endfunction

	// one accepted row into the shadow store; the last row yields a class
	function automatic void absorb_row(row_t r, logic last);
		logic [CLASS_W-1:0] cls;
		if (atom_len < ROW_SLOTS) begin
			atom_rows[atom_len] = r;
			atom_len++;
		end else begin
			atom_overflow = 1'b1;
		end
		if (last) begin
			cls = classify_atom();
			pending_classes.push_back(cls);
			class_tally[cls]++;
			atoms_sent++;
			if (atom_overflow) overflow_atoms++;
			atom_len = 0;
			atom_overflow = 1'b0;
		end
	endfunction

	// offer one word after a random gap, none while tx_steady is set, and wait for the handshake
	task automatic send_row(row_t r, logic last);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			row_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		row_valid <= 1'b1;
		adjacency_row <= r;
		last_row <= last;
		@(posedge clk);
		while (row_stall) @(posedge clk);
		rows_sent++;
		absorb_row(r, last);
	endtask

	task automatic send_atom(row_set_t g, int n);
		for (int i = 0; i < n; i++) begin
			send_row(g[i], i == n - 1);
		end
	endtask

	task automatic send_noise_atom(int len);
		for (int i = 0; i < len; i++) begin
			send_row(row_t'($urandom_range(0, 16383)), i == len - 1);
		end
	endtask

	function automatic row_set_t join_pair(row_set_t g, int a, int b);
		g[a][b] = 1'b1;
		g[b][a] = 1'b1;
		return g;
	endfunction

	// hexagon plus two triangles: twisted gives the cuboctahedron (fcc),
	// eclipsed gives the hcp shell
	function automatic row_set_t cubocta_shell(bit twisted);
		row_set_t g;
		int s;
		g = '0;
		s = twisted ? 1 : 0;
		for (int i = 0; i < 6; i++) begin
			g = join_pair(g, i, (i + 1) % 6);
		end
		for (int j = 0; j < 3; j++) begin
			g = join_pair(g, 6 + j, 6 + (j + 1) % 3);
			g = join_pair(g, 9 + j, 9 + (j + 1) % 3);
			g = join_pair(g, 6 + j, 2 * j);
			g = join_pair(g, 6 + j, 2 * j + 1);
			g = join_pair(g, 9 + j, (2 * j + s) % 6);
			g = join_pair(g, 9 + j, (2 * j + 1 + s) % 6);
		end
		return g;
	endfunction

	// apex, upper ring, lower ring, apex
	function automatic row_set_t icosa_shell();
		row_set_t g;
		g = '0;
		for (int i = 0; i < 5; i++) begin
			g = join_pair(g, 0, 1 + i);
			g = join_pair(g, 11, 6 + i);
			g = join_pair(g, 1 + i, 1 + (i + 1) % 5);
			g = join_pair(g, 6 + i, 6 + (i + 1) % 5);
			g = join_pair(g, 1 + i, 6 + i);
			g = join_pair(g, 1 + i, 6 + (i + 1) % 5);
		end
		return g;
	endfunction

	// cube corners and face centers; bonded at first or second shell distance
	function automatic row_set_t bcc_shell();
		row_set_t g;
		int cx[ROW_SLOTS];
		int cy[ROW_SLOTS];
		int cz[ROW_SLOTS];
		int sgn;
		int d2;
		g = '0;
		for (int i = 0; i < 8; i++) begin
			cx[i] = (i & 1) ? 1 : -1;
			cy[i] = (i & 2) ? 1 : -1;
			cz[i] = (i & 4) ? 1 : -1;
		end
		for (int f = 0; f < 6; f++) begin
			sgn = (f % 2) ? -2 : 2;
			cx[8 + f] = (f / 2 == 0) ? sgn : 0;
			cy[8 + f] = (f / 2 == 1) ? sgn : 0;
			cz[8 + f] = (f / 2 == 2) ? sgn : 0;
		end
		for (int i = 0; i < N14; i++) begin
			for (int j = i + 1; j < N14; j++) begin
				d2 = (cx[i] - cx[j]) ** 2 + (cy[i] - cy[j]) ** 2 + (cz[i] - cz[j]) ** 2;
				if (d2 == 3 || d2 == 4) g = join_pair(g, i, j);
			end
		end
		return g;
	endfunction

	function automatic row_set_t ideal_shell(logic [CLASS_W-1:0] cls);
		case (cls)
			CLASS_FCC: return cubocta_shell(1'b1);
			CLASS_HCP: return cubocta_shell(1'b0);
			CLASS_ICO: return icosa_shell();
			default: return bcc_shell();
		endcase
	endfunction

	function automatic int shell_len(logic [CLASS_W-1:0] cls);
		return (cls == CLASS_BCC) ? N14 : N12;
	endfunction

	// random relabeling of the neighbors
	function automatic row_set_t scramble_shell(row_set_t g, int n);
		int perm[ROW_SLOTS];
		int k;
		int t;
		row_set_t h;
		for (int i = 0; i < n; i++) perm[i] = i;
		for (int i = n - 1; i > 0; i--) begin
			k = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[k];
			perm[k] = t;
		end
		h = '0;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				h[perm[i]][perm[j]] = g[i][j];
			end
		end
		return h;
	endfunction

	// own bit and bits of absent neighbors carry junk
	function automatic row_set_t dirty_unused_bits(row_set_t g, int n);
		for (int i = 0; i < n; i++) begin
			g[i][i] = 1'($urandom_range(0, 1));
			for (int j = n; j < ROW_W; j++) begin
				g[i][j] = 1'($urandom_range(0, 1));
			end
		end
		return g;
	endfunction

	function automatic row_set_t prepared_shell(logic [CLASS_W-1:0] cls);
		return dirty_unused_bits(scramble_shell(ideal_shell(cls), shell_len(cls)),
			shell_len(cls));
	endfunction

	// each lattice in its canonical labeling
	task automatic test_ideal_shells();
		send_atom(dirty_unused_bits(ideal_shell(CLASS_FCC), N12), N12);
		send_atom(dirty_unused_bits(ideal_shell(CLASS_HCP), N12), N12);
		send_atom(dirty_unused_bits(ideal_shell(CLASS_ICO), N12), N12);
		send_atom(dirty_unused_bits(ideal_shell(CLASS_BCC), N14), N14);
	endtask

	// single row, empty and full rows, odd counts, one-sided bond
	task automatic test_edge_atoms();
		row_set_t g;
		send_row({ROW_W{1'b1}}, 1'b1);
		g = '0;
		send_atom(g, N12);
		g = '1;
		send_atom(g, N14);
		g = ideal_shell(CLASS_FCC);
		send_atom(g, N12 + 1);
		g = ideal_shell(CLASS_HCP);
		g[1][0] = 1'b0;
		send_atom(g, N12);
		g = ideal_shell(CLASS_HCP);
		g[0][1] = 1'b0;
		send_atom(g, N12);
	endtask

	// rows past a full store, last flag on the first dropped row and later
	task automatic test_row_overflow();
		row_set_t g;
		g = ideal_shell(CLASS_BCC);
		for (int i = 0; i < N14; i++) send_row(g[i], 1'b0);
		send_row(g[0], 1'b1);
		for (int i = 0; i < N14; i++) send_row(g[i], 1'b0);
		send_row({ROW_W{1'b1}}, 1'b0);
		send_row('0, 1'b0);
		send_row(g[3], 1'b1);
		send_atom(prepared_shell(CLASS_BCC), N14);
	endtask

	// output held off long enough that the atom queue backs up
	task automatic test_full_queue_stall();
		hold_pending = 1'b1;
		tx_steady = 1'b1;
		for (int k = 0; k < 6; k++) begin
			send_atom(prepared_shell(CLASS_W'(k % 4)), shell_len(CLASS_W'(k % 4)));
		end
		tx_steady = 1'b0;
	endtask

	// mostly well-formed shells, some damaged, the rest noise
	task automatic test_random_atoms();
		int start_rows;
		int pick;
		int len;
		logic [CLASS_W-1:0] cls;
		row_set_t g;
		start_rows = rows_sent;
		while (rows_sent - start_rows < RANDOM_ROWS) begin
			tx_steady = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				cls = CLASS_W'($urandom_range(CLASS_FCC, CLASS_ICO));
				len = shell_len(cls);
				g = prepared_shell(cls);
				if ($urandom_range(0, 3) == 0) begin
					g[$urandom_range(0, len - 1)][$urandom_range(0, len - 1)] ^= 1'b1;
				end
				send_atom(g, len);
			end else if (pick == 9) begin
				send_noise_atom($urandom_range(N14 + 1, N14 + 3));
			end else begin
				send_noise_atom($urandom_range(1, N14));
			end
		end
		tx_steady = 1'b0;
	endtask

	// result side: random stalls, steady stretches, and one long hold
	initial begin : class_sink
		int wait_cycles;
		int stretch;
		bit rx_steady;
		class_stall <= 1'b0;
		stretch = 0;
		rx_steady = 1'b0;
		@(posedge arst_n);
		forever begin
			if (stretch == 0) begin
				rx_steady = ($urandom_range(0, 3) == 0);
				stretch = $urandom_range(4, 12);
			end
			stretch--;
			wait_cycles = rx_steady ? 0 : $urandom_range(0, 5);
			if (hold_pending) begin
				wait_cycles = HOLD_CYCLES;
				hold_pending = 1'b0;
				long_holds++;
			end
			if (wait_cycles > 0) begin
				class_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			class_stall <= 1'b0;
			@(posedge clk);
			while (!class_valid) @(posedge clk);
		end
	end

	// compare each accepted class word with the oldest prediction
	always @(posedge clk) begin : class_check
		logic [CLASS_W-1:0] want;
		if (arst_n && class_valid && !class_stall) begin
			if (pending_classes.size() == 0) begin
				log_failure($sformatf("unexpected class word %0d at %0t",
					structure_class, $time));
			end else begin
				want = pending_classes.pop_front();
				if (structure_class !== want) begin
					log_failure($sformatf("class mismatch at %0t: expected %0d, got %0d",
						$time, want, structure_class));
				end
			end
		end
	end

	// ends the run when no word moves on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((row_valid && !row_stall) || (class_valid && !class_stall)) quiet = 0;
			else quiet++;
		end
		$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		row_valid <= 1'b0;
		adjacency_row <= '0;
		last_row <= 1'b0;
		atom_rows = '0;
		atom_len = 0;
		atom_overflow = 1'b0;
		tx_steady = 1'b0;
		hold_pending = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ideal_shells();
		test_edge_atoms();
		test_row_overflow();
		test_full_queue_stall();
		test_random_atoms();
		row_valid <= 1'b0;

		while (pending_classes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_classes.size() != 0) begin
			log_failure($sformatf("%0d class words never arrived", pending_classes.size()));
		end

		$display("run covered %0d atoms over %0d rows, %0d with dropped rows, %0d long holds",
			atoms_sent, rows_sent, overflow_atoms, long_holds);
		$display("fcc %0d, hcp %0d, bcc %0d, ico %0d, other %0d, failures %0d",
			class_tally[CLASS_FCC], class_tally[CLASS_HCP], class_tally[CLASS_BCC],
			class_tally[CLASS_ICO], class_tally[CLASS_OTHER], failures);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
